### hw/rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// implication checked at every rising edge, off while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/stoi_pkg.sv
// constants and helpers of the radix string parser
package stoi_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SYMS_W  = 64;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned IDX_W   = 2;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // parser phases
  localparam logic [1:0] PH_SPACE = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [IDX_W-1:0] REG_SYMBOL_COUNT = 2'd2;

  // reset contents: "0123456789", radix ten
  localparam logic [SYMS_W-1:0]  RST_SYMBOLS_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [SYMS_W-1:0]  RST_SYMBOLS_HIGH = 64'h0000_0000_0000_3938;
  localparam logic [COUNT_W-1:0] RST_SYMBOL_COUNT = 5'd10;

  function automatic logic is_white(input logic [CHAR_W-1:0] c);
    is_white = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

### hw/rtl/string_to_int_any_base_top.sv
// radix string-to-integer parser, top level
//
// Parses a zero-terminated string that arrives one byte per transfer on the
// slave stream. Leading whitespace (space, codes 9 to 13) is skipped, then any
// run of '+' and '-' signs is taken (each '-' flips the sign), then digits are
// accumulated, a digit being the byte's position in the symbol table held in
// symbols_low/symbols_high, with symbol_count as the radix. The first byte that
// is not a digit stops accumulation; bytes after it are ignored up to the zero
// byte. Each zero byte produces exactly one result transfer on the master
// stream: the signed 32-bit value (wrapping modulo 2^32) in tdata and a bad-base
// flag in tuser; with a bad base (count below 2 or above MAX_SYMBOLS, a repeated
// symbol, or a symbol that is zero, '+', '-' or whitespace) the value is 0.
// Throughput is one byte per clock unless the slave side stalls: as a byte sits
// in the input register, the lookup (one comparator per symbol) plus one 32x5
// multiply-add updates the accumulator. A zero byte passes from the input register
// into the result register, which presents its result on the master side. The
// slave side stalls only when a zero byte is ready to finish while the result
// register still holds an untaken result. Configuration writes are taken at any
// edge with cfg_we_i high and must only happen while no string is in flight.
module string_to_int_any_base_top #(
  parameter int unsigned MAX_SYMBOLS = 16  // 2 to 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [stoi_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [stoi_pkg::SYMS_W-1:0]     cfg_wdata_i,
  // byte stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [stoi_pkg::CHAR_W-1:0]     s_axis_tdata,  // [7:0] char_in
  // result stream out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [stoi_pkg::VALUE_W-1:0]    m_axis_tdata,  // [31:0] value (signed)
  output logic                            m_axis_tuser   // [0] base_bad
);
  import stoi_pkg::*;

  localparam int unsigned DIG_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_SYMBOLS);

  // configuration registers
  logic [SYMS_W-1:0]  sym_low_q, sym_high_q;
  logic [COUNT_W-1:0] sym_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_low_q  <= RST_SYMBOLS_LOW;
      sym_high_q <= RST_SYMBOLS_HIGH;
      sym_cnt_q  <= RST_SYMBOL_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SYMBOLS_LOW:  sym_low_q  <= cfg_wdata_i;
        REG_SYMBOLS_HIGH: sym_high_q <= cfg_wdata_i;
        REG_SYMBOL_COUNT: sym_cnt_q  <= cfg_wdata_i[COUNT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // symbol table view
  logic [2*SYMS_W-1:0] sym_all;
  assign sym_all = {sym_high_q, sym_low_q};

  // input register
  logic              in_vld_q;
  logic [CHAR_W-1:0] in_char_q;
  logic              is_term;
  logic              advance;

  // result register
  logic               out_vld_q;
  logic [VALUE_W-1:0] out_val_q;
  logic               out_bad_q;

  assign is_term = (in_char_q == CHAR_NUL);
  // a zero byte needs a free result register, other bytes always move on
  assign advance = in_vld_q && (!is_term || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
    end
  end

  // digit lookup: lowest matching position among the symbols in use
  logic             dig_hit;
  logic [DIG_W-1:0] dig_idx;

  always_comb begin
    dig_hit = 1'b0;
    dig_idx = '0;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if ((sym_all[8*i +: 8] == in_char_q) && (COUNT_W'(i) < sym_cnt_q)) begin
        dig_hit = 1'b1;
        dig_idx = DIG_W'(i);
      end
    end
  end

  // base validity from the registers as they stand
  logic base_bad;

  always_comb begin
    logic [CHAR_W-1:0] s;
    base_bad = (sym_cnt_q < COUNT_W'(2)) || (sym_cnt_q > MAX_CNT);
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      s = sym_all[8*i +: 8];
      if (COUNT_W'(i) < sym_cnt_q) begin
        if ((s == CHAR_NUL) || (s == CHAR_PLUS) || (s == CHAR_MINUS) || is_white(s)) begin
          base_bad = 1'b1;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if ((COUNT_W'(j) < sym_cnt_q) && (sym_all[8*j +: 8] == s)) begin
            base_bad = 1'b1;
          end
        end
      end
    end
  end

  // parser state
  logic [1:0]         phase_q, phase_d;
  logic               neg_q, neg_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [COUNT_W-1:0] radix;
  logic [VALUE_W-1:0] signed_val;

  // count clamped to the table size
  assign radix = (sym_cnt_q > MAX_CNT) ? MAX_CNT : sym_cnt_q;
  assign signed_val = neg_q ? (VALUE_W'(0) - acc_q) : acc_q;

  always_comb begin
    logic [1:0] ph;
    logic       done;
    ph      = phase_q;
    done    = 1'b0;
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if (is_term) begin
      phase_d = PH_SPACE;
      neg_d   = 1'b0;
      acc_d   = '0;
    end else begin
      if (ph == PH_SPACE) begin
        if (is_white(in_char_q)) begin
          done = 1'b1;
        end else begin
          ph = PH_SIGN;
        end
      end
      if (!done && (ph == PH_SIGN)) begin
        if (in_char_q == CHAR_PLUS) begin
          done = 1'b1;
        end else if (in_char_q == CHAR_MINUS) begin
          neg_d = !neg_q;
          done  = 1'b1;
        end else begin
          ph = PH_DIGIT;
        end
      end
      if (!done && (ph == PH_DIGIT)) begin
        if (dig_hit) begin
          acc_d = VALUE_W'(acc_q * VALUE_W'(radix)) + VALUE_W'(dig_idx);
        end else begin
          ph = PH_STOP;
        end
      end
      phase_d = ph;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
    end
  end

  // result register: loaded by a zero byte, freed by a master transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && is_term) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_term) begin
      out_val_q <= base_bad ? '0 : signed_val;
      out_bad_q <= base_bad;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_bad_q;

endmodule

### hw/rtl/stoi_checker.sv
// port-level checks of the radix string parser, bound to its top level
`include "assert_macros.svh"

module stoi_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [stoi_pkg::CHAR_W-1:0]     s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [stoi_pkg::VALUE_W-1:0]    m_axis_tdata,
  input logic                            m_axis_tuser
);
  import stoi_pkg::*;

  logic               term_xfer;
  logic               out_stall;
  logic [VALUE_W:0]   out_word;
  assign term_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tdata == CHAR_NUL);
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tuser, m_axis_tdata};

  // a stalled result holds
  `ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_stall, ##1 (m_axis_tvalid && $stable(out_word)))
  // a bad base always reports zero
  `ASSERT_IMP(a_bad_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  // a fresh result follows a zero byte transfer through the input register
  `ASSERT_IMP(a_out_cause, clk_i, rst_ni, $rose(m_axis_tvalid), $past(term_xfer, 2))
  // input backpressure only while an untaken result blocks
  `ASSERT_CLK(a_stall_why, clk_i, rst_ni, s_axis_tready || (m_axis_tvalid && !m_axis_tready))

endmodule

bind string_to_int_any_base_top stoi_checker u_stoi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
